// ===== design/bmq_pkg.sv =====
// Shared types and constants for the bounded message queue.
`timescale 1ns / 1ps
package bmq_pkg;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_DROP = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    localparam int LEN_W = 7;
    localparam logic [LEN_W-1:0] READ_LIMIT_RST = 7'd80;

    typedef struct packed {
        t_status          status;
        logic [7:0]       out_byte;
        logic             out_byte_valid;
        logic             out_last;
        logic [LEN_W-1:0] msg_length;
    } t_result;

endpackage

// ===== design/bmq_store.sv =====
// Slot byte memory and slot length memory, registered reads.
`timescale 1ns / 1ps
module bmq_store
    import bmq_pkg::*;
#(
    parameter int ADDR_W = 10,
    parameter int DEPTH  = 800,
    parameter int SLOT_W = 4,
    parameter int SLOTS  = 10,
    parameter int POS_W  = 7
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic [SLOT_W-1:0] i_rd_slot,
    output logic [7:0]        o_rd_byte,
    output logic [POS_W-1:0]  o_rd_len,
    input  logic              i_wr_byte_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_byte,
    input  logic              i_wr_len_en,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [POS_W-1:0]  i_wr_len
);

    logic [7:0]       r_bytes [DEPTH];
    logic [POS_W-1:0] r_lens  [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_byte_en) begin
            r_bytes[i_wr_addr] <= i_wr_byte;
        end
        if (i_rd_en) begin
            o_rd_byte <= r_bytes[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_len_en) begin
            r_lens[i_wr_slot] <= i_wr_len;
        end
        if (i_rd_en) begin
            o_rd_len <= r_lens[i_rd_slot];
        end
    end

endmodule

// ===== design/bmq_ctrl.sv =====
// Queue pointers, read limit and the per-item read-modify-write of the slot store.
`timescale 1ns / 1ps
module bmq_ctrl
    import bmq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 10,
    parameter int MSG_BYTES   = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_start,
    input  logic             i_exec,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_byte_valid,
    input  logic             i_in_last,
    output t_result          o_result
);

    localparam int DEPTH  = QUEUE_SLOTS * MSG_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1);
    localparam int POS_W  = $clog2(MSG_BYTES + 1);
    localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_wpos, n_wpos;
    logic [POS_W-1:0]  r_rpos, n_rpos;
    logic              r_dropped, n_dropped;
    logic [LEN_W-1:0]  r_read_limit;

    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [7:0]        rd_byte;
    logic [POS_W-1:0]  rd_len;
    logic              wr_byte_en, wr_len_en;
    logic [POS_W-1:0]  wpos_inc;
    logic [CMP_W-1:0]  len_ext, limit_ext, lim, rpos_ext, rpos_inc;
    t_result           result;

    assign rd_addr = ADDR_W'(r_head) * ADDR_W'(MSG_BYTES) + ADDR_W'(r_rpos);
    assign wr_addr = ADDR_W'(r_tail) * ADDR_W'(MSG_BYTES) + ADDR_W'(r_wpos);

    bmq_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W),
        .SLOTS  (QUEUE_SLOTS),
        .POS_W  (POS_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (i_start),
        .i_rd_addr    (rd_addr),
        .i_rd_slot    (r_head),
        .o_rd_byte    (rd_byte),
        .o_rd_len     (rd_len),
        .i_wr_byte_en (wr_byte_en),
        .i_wr_addr    (wr_addr),
        .i_wr_byte    (i_in_byte),
        .i_wr_len_en  (wr_len_en),
        .i_wr_slot    (r_tail),
        .i_wr_len     (wpos_inc)
    );

    assign len_ext   = CMP_W'(rd_len);
    assign limit_ext = CMP_W'(r_read_limit);
    assign lim       = (len_ext > limit_ext) ? limit_ext : len_ext;
    assign rpos_ext  = CMP_W'(r_rpos);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        n_dropped  = r_dropped;
        wr_byte_en = 1'b0;
        wr_len_en  = 1'b0;
        wpos_inc   = r_wpos;
        rpos_inc   = rpos_ext;
        result     = '{status: ST_OK, out_byte: 8'd0, out_byte_valid: 1'b0,
                       out_last: 1'b0, msg_length: '0};
        if (r_dropped || t_op'(i_op) == OP_DROP) begin
            n_dropped       = 1'b1;
            result.status   = ST_DROPPED;
            result.out_last = 1'b1;
        end else begin
            unique case (t_op'(i_op))
                OP_PUT: begin
                    if (r_count == CNT_W'(QUEUE_SLOTS)) begin
                        result.status = ST_FULL;
                    end else begin
                        if (i_in_byte_valid && r_wpos < POS_W'(MSG_BYTES)) begin
                            wr_byte_en = i_exec;
                            wpos_inc   = r_wpos + 1'b1;
                        end
                        n_wpos = wpos_inc;
                        if (i_in_last) begin
                            wr_len_en         = i_exec;
                            n_tail            = (r_tail == SLOT_W'(QUEUE_SLOTS - 1)) ?
                                                '0 : r_tail + 1'b1;
                            n_count           = r_count + 1'b1;
                            n_wpos            = '0;
                            result.out_last   = 1'b1;
                            result.msg_length = LEN_W'(wpos_inc);
                        end
                    end
                end
                OP_GET: begin
                    if (r_count == '0) begin
                        result.status = ST_EMPTY;
                    end else begin
                        if (rpos_ext < lim) begin
                            result.out_byte       = rd_byte;
                            result.out_byte_valid = 1'b1;
                            rpos_inc              = rpos_ext + 1'b1;
                        end
                        n_rpos = POS_W'(rpos_inc);
                        if (rpos_inc >= lim) begin
                            n_head            = (r_head == SLOT_W'(QUEUE_SLOTS - 1)) ?
                                                '0 : r_head + 1'b1;
                            n_count           = r_count - 1'b1;
                            n_rpos            = '0;
                            result.out_last   = 1'b1;
                            result.msg_length = LEN_W'(lim);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_wpos       <= '0;
            r_rpos       <= '0;
            r_dropped    <= 1'b0;
            r_read_limit <= READ_LIMIT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_read_limit <= i_cfg_wr_data;
            end
            if (i_exec) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
                r_wpos    <= n_wpos;
                r_rpos    <= n_rpos;
                r_dropped <= n_dropped;
            end
        end
    end

endmodule

// ===== design/bounded_message_queue_top.sv =====
// Top level of the bounded message queue: item handshake and result register.
//
// Input channel i_in_valid / o_in_ready carries one item: put byte, get byte
// or drop. Output channel o_out_valid / i_out_ready returns exactly one
// result item per input item, in order. i_cfg_wr_en / i_cfg_wr_data write
// the read limit. The user must do so only while the block is idle; the
// block itself does not enforce this. An accepted item reads the slot
// memories in the accept cycle, and in the next cycle the result is
// computed, memories and pointers are written back and the result register
// is loaded. o_out_valid is registered and rises as that register is loaded.
// No new item is accepted while an item is in its execute state, since the
// slot memory read must come ahead of its write-back.
// A held result does not block the next accept while it is being taken;
// if the receiver stalls, one result is held and further items wait.
// Reset (synchronous, active low) empties the queue, clears the dropped
// state and sets the read limit to 80. Slot contents are not cleared.
`timescale 1ns / 1ps
module bounded_message_queue_top
    import bmq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 10,
    parameter int MSG_BYTES   = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_byte_valid,
    input  logic             i_in_last,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic             o_out_byte_valid,
    output logic             o_out_last,
    output logic [LEN_W-1:0] o_msg_length
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state     r_state;
    logic [1:0] r_op;
    logic [7:0] r_in_byte;
    logic       r_in_byte_valid;
    logic       r_in_last;
    logic       accept;
    t_result    result;

    assign o_in_ready = (r_state == S_IDLE) && (!o_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    bmq_ctrl #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MSG_BYTES   (MSG_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_start         (accept),
        .i_exec          (r_state == S_EXEC),
        .i_op            (r_op),
        .i_in_byte       (r_in_byte),
        .i_in_byte_valid (r_in_byte_valid),
        .i_in_last       (r_in_last),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op            <= i_op;
            r_in_byte       <= i_in_byte;
            r_in_byte_valid <= i_in_byte_valid;
            r_in_last       <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_out_valid && i_out_ready) begin
                        o_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state          <= S_IDLE;
                    o_out_valid      <= 1'b1;
                    o_status         <= result.status;
                    o_out_byte       <= result.out_byte;
                    o_out_byte_valid <= result.out_byte_valid;
                    o_out_last       <= result.out_last;
                    o_msg_length     <= result.msg_length;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
